/* src/pac_pkg.sv */
// Shared types and constants for the polygon area and centroid block.
package pac_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int AREA_W        = 48;
    localparam int SUM_W         = 64;
    localparam int CNT_W         = 7;   // covers 64 + FRAC_BITS steps up to FRAC_BITS of 64

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FEW  = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CMUL,
        OP_CROSS,
        OP_SQ,
        OP_ROOT,
        OP_AREA,
        OP_WMUL,
        OP_WSUM1,
        OP_WSUM2,
        OP_DINIT,
        OP_DIV,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] idx;
        logic             first;
        logic [1:0]       status;
    } cmd_t;

    typedef struct packed {
        logic area_zero;
    } dp_status_t;

endpackage

/* src/pac_if.sv */
// Request channels for vertices in and results out.
interface pac_vertex_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pac_pkg::COORD_W-1:0]   vertex_x;
    logic signed [pac_pkg::COORD_W-1:0]   vertex_y;
    logic signed [pac_pkg::COORD_W-1:0]   vertex_z;
    logic                                 is_last;

    modport source (output valid, vertex_x, vertex_y, vertex_z, is_last, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, is_last, output ready);
endinterface

interface pac_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pac_pkg::COORD_W-1:0]   centroid_x;
    logic signed [pac_pkg::COORD_W-1:0]   centroid_y;
    logic signed [pac_pkg::COORD_W-1:0]   centroid_z;
    logic        [pac_pkg::AREA_W-1:0]    total_area;
    logic        [1:0]                    status;

    modport source (output valid, centroid_x, centroid_y, centroid_z, total_area, status,
                    input ready);
    modport sink   (input valid, centroid_x, centroid_y, centroid_z, total_area, status,
                    output ready);
endinterface

/* src/pac_ctrl.sv */
// Sequencer: steps the datapath through each vertex and the final divide.
module pac_ctrl #(
    parameter int FRAC_BITS = pac_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_last,
    output logic                   in_ready,
    input  logic                   out_ready,
    output logic                   out_valid,
    input  pac_pkg::dp_status_t    dp_status,
    output pac_pkg::cmd_t          cmd
);

    localparam int CW = pac_pkg::CNT_W;
    localparam logic [CW-1:0] CMUL_LAST = CW'(5);
    localparam logic [CW-1:0] SQ_LAST   = CW'(9);
    localparam logic [CW-1:0] ROOT_LAST = CW'(63);
    localparam logic [CW-1:0] WMUL_LAST = CW'(5);
    localparam logic [CW-1:0] DIV_LAST  = CW'(64 + FRAC_BITS - 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CMUL  = 11'b000_0000_0010,
        S_CROSS = 11'b000_0000_0100,
        S_SQ    = 11'b000_0000_1000,
        S_ROOT  = 11'b000_0001_0000,
        S_AREA  = 11'b000_0010_0000,
        S_WMUL  = 11'b000_0100_0000,
        S_WSUM  = 11'b000_1000_0000,
        S_FIN   = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    seen_reg, seen_next;
    logic          last_reg, last_next;
    logic [1:0]    status_reg, status_next;
    logic          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        seen_next      = seen_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = pac_pkg::OP_NONE;
        cmd.idx        = idx_reg;
        cmd.first      = (seen_reg == 2'd0);
        cmd.status     = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op    = pac_pkg::OP_LOAD;
                    seen_next = (seen_reg == 2'd3) ? 2'd3 : seen_reg + 2'd1;
                    last_next = in_last;
                    idx_next  = '0;
                    if (seen_reg >= 2'd2)
                        state_next = S_CMUL;
                    else if (in_last)
                        state_next = S_FIN;
                end
            end
            S_CMUL:
            begin
                cmd.op   = pac_pkg::OP_CMUL;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CMUL_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_CROSS;
                end
            end
            S_CROSS:
            begin
                cmd.op     = pac_pkg::OP_CROSS;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op   = pac_pkg::OP_SQ;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SQ_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                cmd.op   = pac_pkg::OP_ROOT;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == ROOT_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_AREA;
                end
            end
            S_AREA:
            begin
                cmd.op     = pac_pkg::OP_AREA;
                state_next = S_WMUL;
            end
            S_WMUL:
            begin
                cmd.op   = pac_pkg::OP_WMUL;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == WMUL_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_WSUM;
                end
            end
            S_WSUM:
            begin
                if (idx_reg == '0)
                begin
                    cmd.op   = pac_pkg::OP_WSUM1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    cmd.op     = pac_pkg::OP_WSUM2;
                    idx_next   = '0;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                idx_next = '0;
                if (seen_reg != 2'd3)
                begin
                    status_next = pac_pkg::STATUS_FEW;
                    state_next  = S_EMIT;
                end
                else if (dp_status.area_zero)
                begin
                    status_next = pac_pkg::STATUS_ZERO;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.op      = pac_pkg::OP_DINIT;
                    status_next = pac_pkg::STATUS_OK;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op   = pac_pkg::OP_DIV;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == DIV_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = pac_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                    seen_next      = 2'd0;
                    last_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            seen_reg      <= 2'd0;
            last_reg      <= 1'b0;
            status_reg    <= pac_pkg::STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            seen_reg      <= seen_next;
            last_reg      <= last_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* src/pac_dp.sv */
// Datapath: edge vectors, shared 32x32 multiplier, square root, divide-by-3 and divide lanes.
module pac_dp #(
    parameter int FRAC_BITS = pac_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pac_pkg::cmd_t                        cmd,
    input  logic signed [pac_pkg::COORD_W-1:0]   vertex_x,
    input  logic signed [pac_pkg::COORD_W-1:0]   vertex_y,
    input  logic signed [pac_pkg::COORD_W-1:0]   vertex_z,
    output pac_pkg::dp_status_t                  dp_status,
    output logic signed [pac_pkg::COORD_W-1:0]   centroid_x,
    output logic signed [pac_pkg::COORD_W-1:0]   centroid_y,
    output logic signed [pac_pkg::COORD_W-1:0]   centroid_z,
    output logic        [pac_pkg::AREA_W-1:0]    total_area,
    output logic        [1:0]                    status
);

    localparam int AW   = pac_pkg::AREA_W;
    localparam int XW   = 65 - FRAC_BITS;     // cross magnitude width
    localparam int DN_W = 64 + FRAC_BITS;     // divide numerator bits
    localparam int WP_W = 80 + FRAC_BITS;     // weighted product plus saturation headroom

    // floor(x/3) = (x * ceil(2^34/3)) >> 34 for any x below 2^33
    localparam logic [65:0] THIRD_RECIP = 66'h1_5555_5556;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_33 = 2'd1;
    localparam logic [1:0] SH_64 = 2'd2;

    localparam logic [AW-1:0] AREA_MAX = '1;
    localparam logic [63:0]   POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]   NEG_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [32:0]   Q_CAP    = 33'h1_0000_0000;

    // vertex state and derived per-triangle values
    logic signed [31:0] first_reg [3];
    logic signed [31:0] prev_reg  [3];
    logic [31:0]        d1m_reg   [3];
    logic [31:0]        d2m_reg   [3];
    logic               d1n_reg   [3];
    logic               d2n_reg   [3];
    logic [32:0]        smag_reg  [3];
    logic               sneg_reg  [3];
    logic [31:0]        q3_reg    [3];

    logic [63:0]        mprod_reg [6];
    logic               mneg_reg  [6];
    logic [XW-1:0]      cross_reg [3];
    logic [63:0]        prod_reg;
    logic [1:0]         psh_reg;
    logic               pv_reg;
    logic [127:0]       acc_reg;
    logic [127:0]       rad_reg;
    logic [63:0]        root_reg;
    logic [63:0]        rem_reg;
    logic [AW-1:0]      area_reg;
    logic [AW-1:0]      area_sum_reg;
    logic [63:0]        wprod_reg [6];
    logic [WP_W-1:0]    wp_reg    [3];
    logic signed [63:0] wsum_reg  [3];
    logic [DN_W-1:0]    dnum_reg  [3];
    logic [48:0]        drem_reg  [3];
    logic [32:0]        dq_reg    [3];
    logic               dover_reg [3];

    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [AW-1:0]      ta_reg;
    logic [1:0]         st_reg;

    // combinational
    logic signed [31:0] vin   [3];
    logic [32:0]        d1    [3];
    logic [32:0]        d2    [3];
    logic [32:0]        d1neg [3];
    logic [32:0]        d2neg [3];
    logic [33:0]        s34   [3];
    logic [33:0]        s34neg[3];
    logic [31:0]        ma, mb;
    logic               mneg_c;
    logic [1:0]         psh_c;
    logic [63:0]        mul;
    logic [127:0]       acc_term;
    logic [64:0]        xsum  [3];
    logic [64:0]        xdiff [3];
    logic [64:0]        xsel  [3];
    logic [127:0]       rsrc;
    logic [63:0]        remt, trial;
    logic [62:0]        root_half;
    logic [AW:0]        area_add;
    logic [65:0]        d3prod[3];
    logic               wsat  [3];
    logic [63:0]        wmag  [3];
    logic [63:0]        wterm [3];
    logic [64:0]        wadd  [3];
    logic [63:0]        wsum_mag [3];
    logic [49:0]        drt   [3];
    logic [33:0]        dq2   [3];
    logic [32:0]        dlimit[3];
    logic [32:0]        dqf   [3];
    logic [32:0]        dqfneg[3];

    assign vin[0] = vertex_x;
    assign vin[1] = vertex_y;
    assign vin[2] = vertex_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d1[k]     = {prev_reg[k][31], prev_reg[k]} - {first_reg[k][31], first_reg[k]};
            d2[k]     = {vin[k][31], vin[k]} - {first_reg[k][31], first_reg[k]};
            d1neg[k]  = -d1[k];
            d2neg[k]  = -d2[k];
            s34[k]    = {{2{first_reg[k][31]}}, first_reg[k]}
                      + {{2{prev_reg[k][31]}}, prev_reg[k]}
                      + {{2{vin[k][31]}}, vin[k]};
            s34neg[k] = -s34[k];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        ma     = '0;
        mb     = '0;
        mneg_c = 1'b0;
        psh_c  = SH_0;
        unique case (cmd.op)
            pac_pkg::OP_CMUL:
            begin
                case (cmd.idx[2:0])
                    3'd0:    begin ma = d1m_reg[1]; mb = d2m_reg[2]; mneg_c = d1n_reg[1] ^ d2n_reg[2]; end
                    3'd1:    begin ma = d1m_reg[2]; mb = d2m_reg[1]; mneg_c = d1n_reg[2] ^ d2n_reg[1]; end
                    3'd2:    begin ma = d1m_reg[2]; mb = d2m_reg[0]; mneg_c = d1n_reg[2] ^ d2n_reg[0]; end
                    3'd3:    begin ma = d1m_reg[0]; mb = d2m_reg[2]; mneg_c = d1n_reg[0] ^ d2n_reg[2]; end
                    3'd4:    begin ma = d1m_reg[0]; mb = d2m_reg[1]; mneg_c = d1n_reg[0] ^ d2n_reg[1]; end
                    3'd5:    begin ma = d1m_reg[1]; mb = d2m_reg[0]; mneg_c = d1n_reg[1] ^ d2n_reg[0]; end
                    default: begin ma = '0; mb = '0; end
                endcase
            end
            pac_pkg::OP_SQ:
            begin
                case (cmd.idx[3:0])
                    4'd0: begin ma = cross_reg[0][31:0]; mb = cross_reg[0][31:0]; psh_c = SH_0; end
                    4'd1: begin ma = cross_reg[0][31:0]; mb = 32'(cross_reg[0][XW-1:32]); psh_c = SH_33; end
                    4'd2: begin ma = 32'(cross_reg[0][XW-1:32]); mb = 32'(cross_reg[0][XW-1:32]); psh_c = SH_64; end
                    4'd3: begin ma = cross_reg[1][31:0]; mb = cross_reg[1][31:0]; psh_c = SH_0; end
                    4'd4: begin ma = cross_reg[1][31:0]; mb = 32'(cross_reg[1][XW-1:32]); psh_c = SH_33; end
                    4'd5: begin ma = 32'(cross_reg[1][XW-1:32]); mb = 32'(cross_reg[1][XW-1:32]); psh_c = SH_64; end
                    4'd6: begin ma = cross_reg[2][31:0]; mb = cross_reg[2][31:0]; psh_c = SH_0; end
                    4'd7: begin ma = cross_reg[2][31:0]; mb = 32'(cross_reg[2][XW-1:32]); psh_c = SH_33; end
                    4'd8: begin ma = 32'(cross_reg[2][XW-1:32]); mb = 32'(cross_reg[2][XW-1:32]); psh_c = SH_64; end
                    default: begin ma = '0; mb = '0; end
                endcase
            end
            pac_pkg::OP_WMUL:
            begin
                case (cmd.idx[2:0])
                    3'd0:    begin ma = q3_reg[0]; mb = area_reg[31:0]; end
                    3'd1:    begin ma = q3_reg[0]; mb = 32'(area_reg[AW-1:32]); end
                    3'd2:    begin ma = q3_reg[1]; mb = area_reg[31:0]; end
                    3'd3:    begin ma = q3_reg[1]; mb = 32'(area_reg[AW-1:32]); end
                    3'd4:    begin ma = q3_reg[2]; mb = area_reg[31:0]; end
                    3'd5:    begin ma = q3_reg[2]; mb = 32'(area_reg[AW-1:32]); end
                    default: begin ma = '0; mb = '0; end
                endcase
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mul = ma * mb;

    always_comb
    begin
        unique case (psh_reg)
            SH_0:    acc_term = {64'd0, prod_reg};
            SH_33:   acc_term = {31'd0, prod_reg, 33'd0};
            SH_64:   acc_term = {prod_reg, 64'd0};
            default: acc_term = '0;
        endcase
    end

    // cross magnitudes: like signs subtract, unlike signs add
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            xsum[k]  = {1'b0, mprod_reg[2*k]} + {1'b0, mprod_reg[2*k+1]};
            xdiff[k] = (mprod_reg[2*k] >= mprod_reg[2*k+1])
                     ? {1'b0, mprod_reg[2*k] - mprod_reg[2*k+1]}
                     : {1'b0, mprod_reg[2*k+1] - mprod_reg[2*k]};
            xsel[k]  = (mneg_reg[2*k] != mneg_reg[2*k+1]) ? xsum[k] : xdiff[k];
        end
    end

    // one square-root digit per step
    always_comb
    begin
        rsrc      = (cmd.idx == '0) ? acc_reg : rad_reg;
        remt      = {rem_reg[61:0], rsrc[127:126]};
        trial     = {root_reg[61:0], 2'b01};
        root_half = root_reg[63:1];
        area_add  = {1'b0, area_sum_reg} + {1'b0, area_reg};
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d3prod[k] = {33'd0, smag_reg[k]} * THIRD_RECIP;

            wsat[k]  = |wp_reg[k][WP_W-1:63+FRAC_BITS];
            wmag[k]  = wsat[k] ? POS_MAX : {1'b0, wp_reg[k][62+FRAC_BITS:FRAC_BITS]};
            wterm[k] = sneg_reg[k] ? -wmag[k] : wmag[k];
            wadd[k]  = {wsum_reg[k][63], wsum_reg[k]} + {wterm[k][63], wterm[k]};

            wsum_mag[k] = wsum_reg[k][63] ? -wsum_reg[k] : wsum_reg[k];

            drt[k] = {drem_reg[k], dnum_reg[k][DN_W-1]};
            dq2[k] = {dq_reg[k], 1'b0};
            if (drt[k] >= {2'b00, area_sum_reg})
            begin
                drt[k] = drt[k] - {2'b00, area_sum_reg};
                dq2[k] = dq2[k] | 34'd1;
            end

            dlimit[k] = wsum_reg[k][63] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
            dqf[k]    = (dover_reg[k] || dq_reg[k] > dlimit[k]) ? dlimit[k] : dq_reg[k];
            dqfneg[k] = wsum_reg[k][63] ? -dqf[k] : dqf[k];
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        pv_reg  <= (cmd.op == pac_pkg::OP_SQ) && (cmd.idx[3:0] < 4'd9);
        prod_reg <= mul;
        psh_reg  <= psh_c;

        unique case (cmd.op)
            pac_pkg::OP_LOAD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (cmd.first)
                        first_reg[k] <= vin[k];
                    prev_reg[k] <= vin[k];
                    d1m_reg[k]  <= d1[k][32] ? d1neg[k][31:0] : d1[k][31:0];
                    d2m_reg[k]  <= d2[k][32] ? d2neg[k][31:0] : d2[k][31:0];
                    d1n_reg[k]  <= d1[k][32];
                    d2n_reg[k]  <= d2[k][32];
                    smag_reg[k] <= s34[k][33] ? s34neg[k][32:0] : s34[k][32:0];
                    sneg_reg[k] <= s34[k][33];
                    q3_reg[k]   <= '0;
                end
            end
            pac_pkg::OP_CMUL:
            begin
                for (int j = 0; j < 6; j++)
                begin
                    if (cmd.idx[2:0] == 3'(j))
                    begin
                        mprod_reg[j] <= mul;
                        mneg_reg[j]  <= mneg_c;
                    end
                end
            end
            pac_pkg::OP_CROSS:
            begin
                for (int k = 0; k < 3; k++)
                    cross_reg[k] <= xsel[k][64:FRAC_BITS];
                acc_reg <= '0;
            end
            pac_pkg::OP_SQ:
            begin
                if (pv_reg)
                    acc_reg <= acc_reg + acc_term;
                root_reg <= '0;
                rem_reg  <= '0;
            end
            pac_pkg::OP_ROOT:
            begin
                rad_reg <= {rsrc[125:0], 2'b00};
                if (remt >= trial)
                begin
                    rem_reg  <= remt - trial;
                    root_reg <= {root_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= remt;
                    root_reg <= {root_reg[62:0], 1'b0};
                end
                // center magnitudes divided by 3 on the first root step
                if (cmd.idx == '0)
                begin
                    for (int k = 0; k < 3; k++)
                        q3_reg[k] <= d3prod[k][65:34];
                end
            end
            pac_pkg::OP_AREA:
            begin
                area_reg <= (|root_half[62:AW]) ? AREA_MAX : root_half[AW-1:0];
            end
            pac_pkg::OP_WMUL:
            begin
                for (int j = 0; j < 6; j++)
                begin
                    if (cmd.idx[2:0] == 3'(j))
                        wprod_reg[j] <= mul;
                end
            end
            pac_pkg::OP_WSUM1:
            begin
                for (int k = 0; k < 3; k++)
                    wp_reg[k] <= WP_W'(wprod_reg[2*k])
                               + WP_W'({wprod_reg[2*k+1][47:0], 32'd0});
            end
            pac_pkg::OP_DINIT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dnum_reg[k]  <= {wsum_mag[k], {FRAC_BITS{1'b0}}};
                    drem_reg[k]  <= '0;
                    dq_reg[k]    <= '0;
                    dover_reg[k] <= 1'b0;
                end
            end
            pac_pkg::OP_DIV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dnum_reg[k] <= {dnum_reg[k][DN_W-2:0], 1'b0};
                    drem_reg[k] <= drt[k][48:0];
                    if (dq2[k][33] || dq2[k][32])
                    begin
                        dover_reg[k] <= 1'b1;
                        dq_reg[k]    <= Q_CAP;
                    end
                    else
                    begin
                        dq_reg[k] <= dq2[k][32:0];
                    end
                end
            end
            pac_pkg::OP_EMIT:
            begin
                st_reg <= cmd.status;
                unique case (cmd.status)
                    pac_pkg::STATUS_OK:
                    begin
                        cx_reg <= dqfneg[0][31:0];
                        cy_reg <= dqfneg[1][31:0];
                        cz_reg <= dqfneg[2][31:0];
                        ta_reg <= area_sum_reg;
                    end
                    pac_pkg::STATUS_FEW:
                    begin
                        cx_reg <= '0;
                        cy_reg <= '0;
                        cz_reg <= '0;
                        ta_reg <= AW'(1) << FRAC_BITS;
                    end
                    default:
                    begin
                        cx_reg <= '0;
                        cy_reg <= '0;
                        cz_reg <= '0;
                        ta_reg <= '0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_sum_reg <= '0;
            for (int k = 0; k < 3; k++)
                wsum_reg[k] <= '0;
        end
        else
        begin
            if (cmd.op == pac_pkg::OP_WMUL && cmd.idx == '0)
                area_sum_reg <= area_add[AW] ? AREA_MAX : area_add[AW-1:0];
            if (cmd.op == pac_pkg::OP_WSUM2)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (wadd[k][64] != wadd[k][63])
                        wsum_reg[k] <= wadd[k][64] ? NEG_MIN : POS_MAX;
                    else
                        wsum_reg[k] <= wadd[k][63:0];
                end
            end
            if (cmd.op == pac_pkg::OP_EMIT)
            begin
                area_sum_reg <= '0;
                for (int k = 0; k < 3; k++)
                    wsum_reg[k] <= '0;
            end
        end
    end

    assign dp_status.area_zero = (area_sum_reg == '0);
    assign centroid_x = cx_reg;
    assign centroid_y = cy_reg;
    assign centroid_z = cz_reg;
    assign total_area = ta_reg;
    assign status     = st_reg;

endmodule

/* src/polygon_area_centroid.sv */
// Top level: area-weighted centroid of a fan-triangulated 3D polygon.
// Vertices one and two are only loaded; every later vertex keeps the block busy after
// acceptance for 6 cross-product and 9 squaring passes through one shared
// 32x32 multiplier, a 64-step square root, then 6 more multiplies for the weighted sums.
// On the last vertex, unless too few vertices came or the area is zero, the centroid divide runs.
// Asynchronous active-low reset clears the sequencer, vertex count and accumulators.
module polygon_area_centroid #(
    parameter int FRAC_BITS = pac_pkg::FRAC_BITS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    pac_vertex_if.sink    vertex,
    pac_result_if.source  result
);

    pac_pkg::cmd_t        cmd;
    pac_pkg::dp_status_t  dp_status;

    pac_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vertex.valid),
        .in_last   (vertex.is_last),
        .in_ready  (vertex.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    pac_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .vertex_x   (vertex.vertex_x),
        .vertex_y   (vertex.vertex_y),
        .vertex_z   (vertex.vertex_z),
        .dp_status  (dp_status),
        .centroid_x (result.centroid_x),
        .centroid_y (result.centroid_y),
        .centroid_z (result.centroid_z),
        .total_area (result.total_area),
        .status     (result.status)
    );

endmodule

/* src/pac_checker.sv */
// Port-level checks for the polygon centroid block, bound to the top level.
module pac_port_checks #(
    parameter int FRAC_BITS = pac_pkg::FRAC_BITS_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                in_last,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [pac_pkg::COORD_W-1:0]  cx,
    input logic signed [pac_pkg::COORD_W-1:0]  cy,
    input logic signed [pac_pkg::COORD_W-1:0]  cz,
    input logic        [pac_pkg::AREA_W-1:0]   ta,
    input logic        [1:0]                   st
);

    localparam logic [pac_pkg::AREA_W-1:0] ONE = pac_pkg::AREA_W'(1) << FRAC_BITS;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({cx, cy, cz, ta, st}))
        else $error("result payload changed while stalled");

    a_few_area: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && st == pac_pkg::STATUS_FEW |-> ta == ONE)
        else $error("short polygon must report unit area");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && st != pac_pkg::STATUS_OK |-> cx == '0 && cy == '0 && cz == '0)
        else $error("flagged result must carry a zero centroid");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("vertex taken before the polygon result was produced");

endmodule

bind polygon_area_centroid pac_port_checks #(.FRAC_BITS(FRAC_BITS)) u_pac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vertex.valid),
    .in_ready  (vertex.ready),
    .in_last   (vertex.is_last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cx        (result.centroid_x),
    .cy        (result.centroid_y),
    .cz        (result.centroid_z),
    .ta        (result.total_area),
    .st        (result.status)
);

/* tb/sv/pac_checker.sv */
// Scoreboard for the polygon centroid block: predicts each result and compares it.
module pac_checker (
    input  logic         clk,
    input  logic         rst_n,
    pac_vertex_if        vtx,
    pac_result_if        res,
    output int           fail_count,
    output int           pending
);

    localparam int FB = pac_pkg::FRAC_BITS_DEF;
    localparam logic [47:0] AREA_SAT = {pac_pkg::AREA_W{1'b1}};
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [47:0]        area;
        logic [1:0]         status;
    } centroid_t;

    centroid_t   expected_centroids[$];
    longint      v0[3];
    longint      vprev[3];
    int          seen;
    logic [47:0] area_acc;
    longint      moment[3];

    function automatic logic [63:0] mag64(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    // |a*b - c*d| >> FB, exact for 33-bit operands
    function automatic logic [127:0] cross_mag(longint a, longint b, longint c, longint d);
        logic signed [127:0] p;
        p = 128'(signed'(a)) * 128'(signed'(b)) - 128'(signed'(c)) * 128'(signed'(d));
        if (p < 0)
            p = -p;
        return 128'(p) >> FB;
    endfunction

    function automatic logic [127:0] floor_sqrt(logic [127:0] v);
        logic [127:0] root;
        logic [127:0] rem;
        logic [127:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem   = (rem << 2) | v[2*i +: 2];
            trial = (root << 2) | 1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic logic [47:0] tri_area(longint x, longint y, longint z);
        longint       d1[3];
        longint       d2[3];
        logic [127:0] c0, c1, c2, len;
        d1[0] = vprev[0] - v0[0];  d1[1] = vprev[1] - v0[1];  d1[2] = vprev[2] - v0[2];
        d2[0] = x - v0[0];         d2[1] = y - v0[1];         d2[2] = z - v0[2];
        c0 = cross_mag(d1[1], d2[2], d1[2], d2[1]);
        c1 = cross_mag(d1[2], d2[0], d1[0], d2[2]);
        c2 = cross_mag(d1[0], d2[1], d1[1], d2[0]);
        len = floor_sqrt(c0 * c0 + c1 * c1 + c2 * c2) >> 1;
        return len > 128'(AREA_SAT) ? AREA_SAT : len[47:0];
    endfunction

    function automatic longint moment_term(longint center, logic [47:0] area);
        logic [127:0] q;
        q = (128'(mag64(center)) * 128'(area)) >> FB;
        if (q > 128'(S64_MAX))
            q = 128'(S64_MAX);
        return center < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint sat_add64(longint a, longint b);
        logic signed [64:0] t;
        t = 65'(signed'(a)) + 65'(signed'(b));
        if (t > 65'(signed'(S64_MAX)))
            return S64_MAX;
        if (t < 65'(signed'(S64_MIN)))
            return S64_MIN;
        return longint'(t[63:0]);
    endfunction

    function automatic logic signed [31:0] centroid_div(longint s, logic [47:0] den);
        logic [127:0] q;
        logic [127:0] lim;
        q   = (128'(mag64(s)) << FB) / 128'(den);
        lim = s < 0 ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
            q = lim;
        return s < 0 ? -q[31:0] : q[31:0];
    endfunction

    function automatic void clear_polygon();
        for (int k = 0; k < 3; k++)
        begin
            v0[k]     = 0;
            vprev[k]  = 0;
            moment[k] = 0;
        end
        seen     = 0;
        area_acc = '0;
    endfunction

    function automatic void take_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                                        logic signed [31:0] vz, logic last);
        longint      v[3];
        logic [48:0] acc;
        logic [47:0] a;
        longint      center;
        centroid_t   e;
        v[0] = vx;  v[1] = vy;  v[2] = vz;
        if (seen == 0)
            for (int k = 0; k < 3; k++)
                v0[k] = v[k];
        if (seen >= 2)
        begin
            a   = tri_area(v[0], v[1], v[2]);
            acc = 49'(area_acc) + 49'(a);
            area_acc = acc > 49'(AREA_SAT) ? AREA_SAT : acc[47:0];
            for (int k = 0; k < 3; k++)
            begin
                center    = (v0[k] + vprev[k] + v[k]) / 3;
                moment[k] = sat_add64(moment[k], moment_term(center, a));
            end
        end
        for (int k = 0; k < 3; k++)
            vprev[k] = v[k];
        if (seen < 3)
            seen++;
        if (!last)
            return;
        e.cx = 0;  e.cy = 0;  e.cz = 0;
        if (seen < 3)
        begin
            e.area   = 48'(1) << FB;
            e.status = pac_pkg::STATUS_FEW;
        end
        else if (area_acc == 0)
        begin
            e.area   = '0;
            e.status = pac_pkg::STATUS_ZERO;
        end
        else
        begin
            e.cx     = centroid_div(moment[0], area_acc);
            e.cy     = centroid_div(moment[1], area_acc);
            e.cz     = centroid_div(moment[2], area_acc);
            e.area   = area_acc;
            e.status = pac_pkg::STATUS_OK;
        end
        expected_centroids.push_back(e);
        clear_polygon();
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        clear_polygon();
    end

    always @(posedge clk)
    begin
        centroid_t e;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (expected_centroids.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result cx=%h cy=%h cz=%h area=%h status=%0d",
                             $time, res.centroid_x, res.centroid_y, res.centroid_z,
                             res.total_area, res.status);
                end
                else
                begin
                    e = expected_centroids.pop_front();
                    if (res.centroid_x !== e.cx || res.centroid_y !== e.cy ||
                        res.centroid_z !== e.cz || res.total_area !== e.area ||
                        res.status !== e.status)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected cx=%h cy=%h cz=%h area=%h status=%0d",
                                 $time, e.cx, e.cy, e.cz, e.area, e.status);
                        $display("%0t:          actual   cx=%h cy=%h cz=%h area=%h status=%0d",
                                 $time, res.centroid_x, res.centroid_y, res.centroid_z,
                                 res.total_area, res.status);
                    end
                end
            end
            if (vtx.valid && vtx.ready)
                take_vertex(vtx.vertex_x, vtx.vertex_y, vtx.vertex_z, vtx.is_last);
            pending = expected_centroids.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top: vertex stimulus, result back-pressure and the final verdict.
module tb;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int CALM_ITEMS   = 200;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    int   sent;
    bit   calm;
    int   stall_left;

    pac_vertex_if vin();
    pac_result_if res();

    polygon_area_centroid dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vin),
        .result (res)
    );

    pac_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .vtx        (vin),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("polygon_area_centroid verification failed");
            $finish;
        end
    end

    // result-side stalls in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            res.ready  <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end
        else
            res.ready <= 1'b1;
    end

    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            vin.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        vin.valid    <= 1'b1;
        vin.vertex_x <= x;
        vin.vertex_y <= y;
        vin.vertex_z <= z;
        vin.is_last  <= last;
        forever
        begin
            @(posedge clk);
            if (vin.ready)
                break;
        end
        sent++;
    endtask

    task automatic go_quiet();
        @(negedge clk);
        vin.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coord(int kind);
        case (kind)
            0:       return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
            1:       return $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
        endcase
    endfunction

    task automatic send_polygon(int count, int kind);
        for (int i = 0; i < count; i++)
            send_vertex(pick_coord(kind), pick_coord(kind), pick_coord(kind), i == count - 1);
    endtask

    initial
    begin
        int n;
        int kind;
        rst_n        = 1'b0;
        cycles       = 0;
        sent         = 0;
        calm         = 1'b0;
        stall_left   = 0;
        vin.valid    = 1'b0;
        vin.vertex_x = '0;
        vin.vertex_y = '0;
        vin.vertex_z = '0;
        vin.is_last  = 1'b0;
        res.ready    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single vertex, then two vertices: too few for a triangle
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
        send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h0001_0000, 32'h0, 32'h0, 1'b1);
        // unit right triangle in the xy plane
        send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h0, 32'h0001_0000, 32'h0, 1'b1);
        // collinear points: zero area
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_vertex(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 1'b0);
        send_vertex(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 1'b1);
        go_quiet();
        wait (pending == 0);
        // square with negative coordinates, parallel to the yz plane
        send_vertex(32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFE_0000, 1'b0);
        send_vertex(32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000, 1'b0);
        send_vertex(32'hFFFF_0000, 32'h0002_0000, 32'h0002_0000, 1'b0);
        send_vertex(32'hFFFF_0000, 32'hFFFE_0000, 32'h0002_0000, 1'b1);
        // extreme corners: area and sums saturate
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        // tiny triangle whose area truncates to zero
        send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h1, 32'h0, 32'h0, 1'b0);
        send_vertex(32'h0, 32'h1, 32'h0, 1'b1);
        // far-off triangle near the extreme corner: its area truncates to zero
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h7FFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0010, 32'h7FFF_FFFF, 1'b1);

        while (sent < 1700)
        begin
            if (sent > 1700 - CALM_ITEMS)
                calm = 1'b1;
            n = $urandom_range(0, 9);
            if (n == 0)
                n = $urandom_range(1, 2);
            else if (n == 9)
                n = $urandom_range(7, 12);
            else
                n = $urandom_range(3, 6);
            kind = $urandom_range(0, 9);
            kind = kind < 4 ? 0 : kind < 7 ? 3 : kind < 9 ? 1 : 2;
            send_polygon(n, kind);
        end
        go_quiet();
        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("polygon_area_centroid verification clean");
        else
            $display("polygon_area_centroid verification failed");
        $finish;
    end

endmodule
